### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ffpc_pkg.sv
// Package: payload types, register indexes and constants of the controller.
`default_nettype none
package ffpc_pkg;
    typedef struct packed {
        logic              emergency_stop;
        logic [1:0]        mode;
        logic              fan_manual_hold;
        logic              pump_manual_hold;
        logic              occupied;
        logic signed [11:0] temperature;
        logic [9:0]        air_humidity;
        logic [6:0]        soil_humidity;
        logic [8:0]        rain_chance;
        logic              pump_running;
    } t_in_item;

    typedef struct packed {
        logic       fan_drive_valid;
        logic [6:0] fan_speed;
        logic       pump_drive_valid;
        logic       pump_command;
    } t_out_item;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_SMART  = 2'd2;

    localparam int CFG_W = 12;
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_HEAT_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEAT_HIGH = 3'd1;
    localparam logic [IDX_W-1:0] REG_AIR_LOW   = 3'd2;
    localparam logic [IDX_W-1:0] REG_AIR_HIGH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PUMP_ON   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRY_LOW   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRY_HIGH  = 3'd6;

    // Job queue size
    localparam int QDEPTH_LOG2 = 2;
    localparam int QDEPTH      = 1 << QDEPTH_LOG2;

    // Divider request slots
    localparam int NUM_DIV = 3;
    localparam int DIV_HEAT = 0;
    localparam int DIV_AIR  = 1;
    localparam int DIV_DRY  = 2;

    // Classified job passed from front to back
    typedef struct packed {
        logic        fan_on;
        logic        fan_zero;      // smart mode, nobody present
        logic        pump_on;
        logic [1:0]  mode;
        logic        running;
        logic [8:0]  rain_sat;
        logic [2:0]  sat_one;       // membership saturated at one
        logic [2:0]  sat_zero;      // membership saturated at zero
        logic [12:0] num_heat;
        logic [12:0] den_heat;
        logic [12:0] num_air;
        logic [12:0] den_air;
        logic [12:0] num_dry;
        logic [12:0] den_dry;
        logic        auto_cmd;
    } t_job;
endpackage
`default_nettype wire

### rtl/ffpc_front.sv
// Front end: classifies a snapshot and prepares the division operands.
`default_nettype none
module ffpc_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_take,
    input  wire ffpc_pkg::t_in_item i_item,
    input  wire logic signed [11:0] i_heat_low,
    input  wire logic signed [11:0] i_heat_high,
    input  wire logic [9:0]         i_air_low,
    input  wire logic [9:0]         i_air_high,
    input  wire logic [6:0]         i_pump_on,
    input  wire logic [6:0]         i_dry_low,
    input  wire logic [6:0]         i_dry_high,
    output logic                    o_valid,
    output ffpc_pkg::t_job          o_job
);
    import ffpc_pkg::*;

    logic        r_valid;
    t_job        r_job;
    t_job        n_job;
    logic [7:0]  off_lvl;
    logic signed [12:0] t13, hl13, hh13;
    logic [9:0]  air;
    logic [6:0]  soil;

    always_comb begin
        t13  = 13'(i_item.temperature);
        hl13 = 13'(i_heat_low);
        hh13 = 13'(i_heat_high);
        air  = i_item.air_humidity;
        soil = i_item.soil_humidity;
        off_lvl = 8'(i_pump_on) + 8'd5;
        if (off_lvl > 8'd100) off_lvl = 8'd100;

        n_job = '0;
        n_job.fan_on  = !i_item.emergency_stop && i_item.mode != MODE_MANUAL
                        && !i_item.fan_manual_hold;
        n_job.pump_on = !i_item.emergency_stop && i_item.mode != MODE_MANUAL
                        && !i_item.pump_manual_hold;
        n_job.fan_zero = i_item.mode == MODE_SMART && !i_item.occupied;
        n_job.mode    = i_item.mode;
        n_job.running = i_item.pump_running;
        n_job.rain_sat = (i_item.rain_chance > 9'd256) ? 9'd256 : i_item.rain_chance;

        // rising: zero at or below low wins over one at or above high
        n_job.sat_zero[DIV_HEAT] = t13 <= hl13;
        n_job.sat_one[DIV_HEAT]  = !(t13 <= hl13) && t13 >= hh13;
        n_job.num_heat = 13'(t13 - hl13);
        n_job.den_heat = 13'(hh13 - hl13);

        n_job.sat_zero[DIV_AIR] = air <= i_air_low;
        n_job.sat_one[DIV_AIR]  = !(air <= i_air_low) && air >= i_air_high;
        n_job.num_air = 13'(air - i_air_low);
        n_job.den_air = 13'(i_air_high - i_air_low);

        // falling: one at or below low, zero at or above high
        n_job.sat_one[DIV_DRY]  = soil <= i_dry_low;
        n_job.sat_zero[DIV_DRY] = !(soil <= i_dry_low) && soil >= i_dry_high;
        n_job.num_dry = 13'(i_dry_high - soil);
        n_job.den_dry = 13'(i_dry_high - i_dry_low);

        if (soil <= i_pump_on)           n_job.auto_cmd = 1'b1;
        else if (8'(soil) >= off_lvl)    n_job.auto_cmd = 1'b0;
        else                             n_job.auto_cmd = i_item.pump_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        if (i_take) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

### rtl/ffpc_queue.sv
// Short FIFO of classified jobs between front and back.
`default_nettype none
module ffpc_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire ffpc_pkg::t_job i_job,
    input  wire            i_pop,
    output logic           o_empty,
    output logic           o_full,
    output ffpc_pkg::t_job o_job
);
    import ffpc_pkg::*;

    localparam int DEPTH_LOG2 = QDEPTH_LOG2;
    localparam int DEPTH = QDEPTH;

    t_job                r_mem [DEPTH];
    logic [DEPTH_LOG2:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
        if (i_push) r_mem[r_wp[DEPTH_LOG2-1:0]] <= i_job;
    end

    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[DEPTH_LOG2-1:0] == r_rp[DEPTH_LOG2-1:0])
                     && (r_wp[DEPTH_LOG2] != r_rp[DEPTH_LOG2]);
    assign o_job   = r_mem[r_rp[DEPTH_LOG2-1:0]];
endmodule
`default_nettype wire

### rtl/ffpc_back.sv
// Back end: bit-serial dividers for memberships, then fan and pump decisions.
`default_nettype none
module ffpc_back #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_avail,
    input  wire ffpc_pkg::t_job   i_job,
    output logic                  o_pop,
    output logic                  o_busy,
    output logic                  o_strobe,
    output ffpc_pkg::t_out_item   o_item
);
    import ffpc_pkg::*;

    localparam int NW = 13 + FRACTION_BITS;   // dividend width
    localparam int QW = FRACTION_BITS + 1;    // quotient fits in ONE
    localparam int CW = $clog2(NW + 1);
    localparam int DW = FRACTION_BITS + 1;
    localparam int PW = DW + 15;
    localparam logic [PW-1:0] SCALE = PW'(1) << (FRACTION_BITS + 8);

    logic           r_busy, r_stage2, r_strobe;
    logic [CW-1:0]  r_cnt;
    t_job           r_job;
    logic [NW-1:0]  r_num [NUM_DIV];
    logic [12:0]    r_rem [NUM_DIV];
    logic [NW-1:0]  r_quo [NUM_DIV];
    logic [PW-1:0]  r_prod;
    logic [DW-1:0]  r_dem;
    t_out_item      r_item;
    logic [12:0]    den [NUM_DIV];
    logic [13:0]    trial [NUM_DIV];
    logic [DW-1:0]  mem [NUM_DIV];
    logic [DW-1:0]  dem;
    logic [14:0]    wgt;
    logic [DW+6:0]  spd_full;
    logic [7:0]     spd;
    t_out_item      n_item;

    always_comb begin
        den[DIV_HEAT] = i_job.den_heat;
        den[DIV_AIR]  = i_job.den_air;
        den[DIV_DRY]  = i_job.den_dry;
        if (r_busy) begin
            den[DIV_HEAT] = r_job.den_heat;
            den[DIV_AIR]  = r_job.den_air;
            den[DIV_DRY]  = r_job.den_dry;
        end
        for (int k = 0; k < NUM_DIV; k++) begin
            trial[k] = {r_rem[k], r_num[k][NW-1]};
        end
    end

    assign o_pop  = i_avail && !r_busy && !r_stage2;
    assign o_busy = r_busy || r_stage2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_stage2 <= 1'b0;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_strobe <= r_stage2;
            r_stage2 <= r_busy && r_cnt == CW'(1);
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
        end
        if (o_pop) begin
            r_job <= i_job;
            r_num[DIV_HEAT] <= {i_job.num_heat, FRACTION_BITS'(0)};
            r_num[DIV_AIR]  <= {i_job.num_air,  FRACTION_BITS'(0)};
            r_num[DIV_DRY]  <= {i_job.num_dry,  FRACTION_BITS'(0)};
            for (int k = 0; k < NUM_DIV; k++) begin
                r_rem[k] <= '0;
                r_quo[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < NUM_DIV; k++) begin
                r_num[k] <= r_num[k] << 1;
                if (trial[k] >= {1'b0, den[k]}) begin
                    r_rem[k] <= 13'(trial[k] - {1'b0, den[k]});
                    r_quo[k] <= {r_quo[k][NW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[k][12:0];
                    r_quo[k] <= {r_quo[k][NW-2:0], 1'b0};
                end
            end
        end
        if (r_busy && r_cnt == CW'(1)) begin
            r_dem  <= dem;
            r_prod <= PW'(mem[DIV_DRY]) * PW'(wgt);
        end
        if (r_stage2) r_item <= n_item;
    end

    always_comb begin
        for (int k = 0; k < NUM_DIV; k++) begin
            if (r_job.sat_one[k])       mem[k] = DW'(1) << FRACTION_BITS;
            else if (r_job.sat_zero[k]) mem[k] = '0;
            else if (trial[k] >= {1'b0, den[k]})
                mem[k] = DW'({r_quo[k][QW-2:0], 1'b1});
            else
                mem[k] = DW'({r_quo[k][QW-2:0], 1'b0});
        end
        dem = (mem[DIV_HEAT] > mem[DIV_AIR]) ? mem[DIV_HEAT] : mem[DIV_AIR];
        wgt = 15'd25600 - 15'(r_job.rain_sat * 15'd85);

        spd_full = (DW+7)'(r_dem) * (DW+7)'(75);
        spd = 8'd25 + 8'(spd_full >> FRACTION_BITS);
        if (spd > 8'd100) spd = 8'd100;

        n_item = '0;
        if (r_job.fan_on) begin
            n_item.fan_drive_valid = 1'b1;
            if ((DW+5)'(r_dem) * (DW+5)'(20) >= (DW+5)'(1) << FRACTION_BITS
                && !r_job.fan_zero)
                n_item.fan_speed = spd[6:0];
        end
        if (r_job.pump_on) begin
            n_item.pump_drive_valid = 1'b1;
            case (r_job.mode)
                MODE_AUTO:  n_item.pump_command = r_job.auto_cmd;
                MODE_SMART: begin
                    if (r_prod >= PW'(45) * SCALE)      n_item.pump_command = 1'b1;
                    else if (r_prod <= PW'(25) * SCALE) n_item.pump_command = 1'b0;
                    else                                n_item.pump_command = r_job.running;
                end
                default:    n_item.pump_command = 1'b0;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;
endmodule
`default_nettype wire

### rtl/fuzzy_fan_and_pump_controller_core.sv
// Top level: fuzzy fan and hysteresis pump controller core.
//  channel | handshake          | payload
//  input   | i_start / o_busy   | i_item (t_in_item)
//  result  | o_done strobe      | o_result (t_out_item)
//  config  | i_cfg_we           | i_cfg_idx, i_cfg_data
// A snapshot passes the front register and the queue, then the back end, which runs
// one bit per cycle in three shared-step dividers and registers the decision.
// The back end takes no new job until it is through with the last; a four-entry queue
// lets the front take snapshots meanwhile; o_busy rises while four jobs wait.
// Reset is synchronous and loads the register defaults; results cannot stall.
`default_nettype none
module fuzzy_fan_and_pump_controller_core #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    output logic                      o_busy,
    input  wire ffpc_pkg::t_in_item   i_item,
    output logic                      o_done,
    output ffpc_pkg::t_out_item       o_result,
    input  wire                       i_cfg_we,
    input  wire [ffpc_pkg::IDX_W-1:0] i_cfg_idx,
    input  wire [ffpc_pkg::CFG_W-1:0] i_cfg_data
);
    import ffpc_pkg::*;
`include "assert_macros.svh"

    logic signed [11:0] r_heat_low, r_heat_high;
    logic [9:0]  r_air_low, r_air_high;
    logic [6:0]  r_pump_on, r_dry_low, r_dry_high;
    logic        take, f_valid, q_empty, q_full, pop, b_busy;
    t_job        f_job, q_job;
    logic [QDEPTH_LOG2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_low  <= 12'sd250;
            r_heat_high <= 12'sd350;
            r_air_low   <= 10'd400;
            r_air_high  <= 10'd800;
            r_pump_on   <= 7'd30;
            r_dry_low   <= 7'd20;
            r_dry_high  <= 7'd60;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEAT_LOW:  r_heat_low  <= i_cfg_data;
                REG_HEAT_HIGH: r_heat_high <= i_cfg_data;
                REG_AIR_LOW:   r_air_low   <= i_cfg_data[9:0];
                REG_AIR_HIGH:  r_air_high  <= i_cfg_data[9:0];
                REG_PUMP_ON:   r_pump_on   <= i_cfg_data[6:0];
                REG_DRY_LOW:   r_dry_low   <= i_cfg_data[6:0];
                REG_DRY_HIGH:  r_dry_high  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Front register plus queue must never overflow: count jobs not yet popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= '0;
        else r_inflight <= r_inflight + (QDEPTH_LOG2+1)'(take)
                           - (QDEPTH_LOG2+1)'(pop);
    end

    assign o_busy = r_inflight >= (QDEPTH_LOG2+1)'(QDEPTH);
    assign take   = i_start && !o_busy;

    ffpc_front u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_item,
        .i_heat_low(r_heat_low), .i_heat_high(r_heat_high),
        .i_air_low(r_air_low), .i_air_high(r_air_high),
        .i_pump_on(r_pump_on), .i_dry_low(r_dry_low), .i_dry_high(r_dry_high),
        .o_valid(f_valid), .o_job(f_job)
    );

    ffpc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job), .i_pop(pop),
        .o_empty(q_empty), .o_full(q_full), .o_job(q_job)
    );

    ffpc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk, .i_rst_n, .i_avail(!q_empty), .i_job(q_job),
        .o_pop(pop), .o_busy(b_busy), .o_strobe(o_done), .o_item(o_result)
    );

    `CHK_IMPL(a_no_overflow, i_clk, i_rst_n, f_valid, !q_full)
    `CHK_IMPL(a_pop_nonempty, i_clk, i_rst_n, pop, !q_empty)
    `CHK_NEXT(a_pop_busy, i_clk, i_rst_n, pop, b_busy)
    `CHK_IMPL(a_fan_zero, i_clk, i_rst_n, o_done && !o_result.fan_drive_valid,
              o_result.fan_speed == 7'd0)
endmodule
`default_nettype wire
